### rtl/i2cbs_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
`timescale 1ns / 1ps

package i2cbs_pkg;

  localparam int unsigned DELAY_BITS = 8;
  localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(10);

  typedef enum logic [2:0] {
    CMD_IDLE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_SEND    = 3'd3,
    CMD_READ    = 3'd4,
    CMD_WAITACK = 3'd5,
    CMD_ACK     = 3'd6,
    CMD_NACK    = 3'd7
  } cmd_e;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;
  } res_t;

endpackage

### rtl/i2cbs_core.sv
// Command sequencer: holds the bus state and advances it by one tick per transaction.
`timescale 1ns / 1ps

module i2cbs_core import i2cbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [2:0]            operation_i,
  input  logic [7:0]            write_data_i,
  input  logic                  sda_sample_i,
  input  logic [DELAY_BITS-1:0] delay_i,
  output res_t                  res_o
);

  cmd_e                  cmd_q, cmd_d, cmd_cur, op;
  logic [2:0]            phase_q, phase_d, phase_cur;
  logic [3:0]            bit_q, bit_d, bit_cur, bit_next;
  logic [DELAY_BITS-1:0] wait_q, wait_d;
  logic [7:0]            shift_q, shift_d, shift_cur;
  logic [7:0]            read_q, read_d;
  logic                  scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
  logic                  run, done;

  assign op       = cmd_e'(operation_i);
  assign bit_next = bit_cur + 4'd1;

  always_comb begin : next_state
    cmd_cur   = cmd_q;
    phase_cur = phase_q;
    bit_cur   = bit_q;
    shift_cur = shift_q;
    run       = 1'b0;
    done      = 1'b0;
    cmd_d     = cmd_q;
    phase_d   = phase_q;
    bit_d     = bit_q;
    wait_d    = wait_q;
    shift_d   = shift_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    ack_d     = ack_q;
    read_d    = read_q;

    if (cmd_q == CMD_IDLE) begin
      if (op != CMD_IDLE) begin
        cmd_cur   = op;
        cmd_d     = op;
        phase_cur = 3'd0;
        bit_cur   = 4'd0;
        shift_cur = (op == CMD_SEND) ? write_data_i : 8'd0;
        run       = 1'b1;
      end
    end else if (wait_q <= DELAY_BITS'(1)) begin
      run = 1'b1;
    end else begin
      wait_d = wait_q - DELAY_BITS'(1);
    end

    if (run) begin
      phase_d = phase_cur;
      bit_d   = bit_cur;
      shift_d = shift_cur;
      wait_d  = '0;
      unique case (cmd_cur)
        CMD_START: begin
          if (phase_cur == 3'd0) begin
            sda_d = 1'b1; scl_d = 1'b1; phase_d = 3'd1; wait_d = delay_i;
          end else if (phase_cur == 3'd1) begin
            sda_d = 1'b0; phase_d = 3'd2; wait_d = delay_i;
          end else if (phase_cur == 3'd2) begin
            scl_d = 1'b0; phase_d = 3'd3; wait_d = delay_i;
          end else begin
            done = 1'b1;
          end
        end
        CMD_STOP: begin
          if (phase_cur == 3'd0) begin
            sda_d = 1'b0; scl_d = 1'b1; phase_d = 3'd1; wait_d = delay_i;
          end else begin
            sda_d = 1'b1; done = 1'b1;
          end
        end
        CMD_SEND: begin
          if (phase_cur == 3'd0) begin
            sda_d = shift_cur[7]; phase_d = 3'd1; wait_d = delay_i;
          end else if (phase_cur == 3'd1) begin
            scl_d = 1'b1; phase_d = 3'd2; wait_d = delay_i;
          end else if (phase_cur == 3'd2) begin
            scl_d = 1'b0;
            if (bit_cur == 4'd7) begin
              sda_d = 1'b1;
            end
            shift_d = {shift_cur[6:0], 1'b0};
            bit_d   = bit_next;
            phase_d = (bit_next >= 4'd8) ? 3'd3 : 3'd0;
            wait_d  = delay_i;
          end else begin
            done = 1'b1;
          end
        end
        CMD_READ: begin
          if (phase_cur == 3'd0) begin
            scl_d = 1'b1; phase_d = 3'd1; wait_d = delay_i;
          end else if (phase_cur == 3'd1) begin
            shift_d = {shift_cur[6:0], sda_sample_i};
            scl_d   = 1'b0;
            bit_d   = bit_next;
            phase_d = (bit_next >= 4'd8) ? 3'd2 : 3'd0;
            wait_d  = delay_i;
          end else begin
            read_d = shift_cur; done = 1'b1;
          end
        end
        CMD_WAITACK: begin
          if (phase_cur == 3'd0) begin
            sda_d = 1'b1; phase_d = 3'd1; wait_d = delay_i;
          end else if (phase_cur == 3'd1) begin
            scl_d = 1'b1; phase_d = 3'd2; wait_d = delay_i;
          end else if (phase_cur == 3'd2) begin
            ack_d = sda_sample_i; scl_d = 1'b0; phase_d = 3'd3; wait_d = delay_i;
          end else begin
            done = 1'b1;
          end
        end
        CMD_ACK: begin
          if (phase_cur == 3'd0) begin
            sda_d = 1'b0; phase_d = 3'd1; wait_d = delay_i;
          end else if (phase_cur == 3'd1) begin
            scl_d = 1'b1; phase_d = 3'd2; wait_d = delay_i;
          end else if (phase_cur == 3'd2) begin
            scl_d = 1'b0; phase_d = 3'd3; wait_d = delay_i;
          end else begin
            sda_d = 1'b1; done = 1'b1;
          end
        end
        CMD_NACK: begin
          if (phase_cur == 3'd0) begin
            sda_d = 1'b1; phase_d = 3'd1; wait_d = delay_i;
          end else if (phase_cur == 3'd1) begin
            scl_d = 1'b1; phase_d = 3'd2; wait_d = delay_i;
          end else if (phase_cur == 3'd2) begin
            scl_d = 1'b0; phase_d = 3'd3; wait_d = delay_i;
          end else begin
            done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end

    if (done) begin
      cmd_d   = CMD_IDLE;
      phase_d = 3'd0;
      bit_d   = 4'd0;
      wait_d  = '0;
    end
  end

  always_comb begin : result
    res_o.scl_level   = scl_d;
    res_o.sda_level   = sda_d;
    res_o.busy_res    = (cmd_d != CMD_IDLE);
    res_o.done_res    = done;
    res_o.read_data   = read_d;
    res_o.ack_missing = ack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_IDLE;
      phase_q <= 3'd0;
      bit_q   <= 4'd0;
      wait_q  <= '0;
      shift_q <= 8'd0;
      read_q  <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      ack_q   <= 1'b0;
    end else if (step_i) begin
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      wait_q  <= wait_d;
      shift_q <= shift_d;
      read_q  <= read_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
    end
  end

endmodule

### rtl/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master bit sequencer: handshakes, delay register and result register.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   operation_i, write_data_i, sda_sample_i
//   out      output     out_valid_o / out_ready_i scl_level_o, sda_level_o, busy_res_o,
//                                                 done_res_o, read_data_o, ack_missing_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_delay_ticks_i
//
// Each input transaction is one tick and is processed in the cycle it is accepted; its
// result appears in the output register on the next cycle, so one transaction per cycle
// is sustained with out_ready_i high. The output register is the only stage between the two
// sides: a new transaction is taken whenever it is empty or being emptied in the same cycle.
// Reset clears the bus state to idle with both lines released and the delay set to ten.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_unit import i2cbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] write_data_i,
  input  logic       sda_sample_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_data_o,
  output logic       ack_missing_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_delay_ticks_i
);

  logic [DELAY_BITS-1:0] delay_q;
  logic                  out_valid_q;
  res_t                  res, res_q;
  logic                  accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  i2cbs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (accept),
    .operation_i  (operation_i),
    .write_data_i (write_data_i),
    .sda_sample_i (sda_sample_i),
    .delay_i      (delay_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RESET;
    end else if (cfg_valid_i) begin
      delay_q <= DELAY_BITS'(cfg_delay_ticks_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_level_o   = res_q.scl_level;
  assign sda_level_o   = res_q.sda_level;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign read_data_o   = res_q.read_data;
  assign ack_missing_o = res_q.ack_missing;

endmodule

### bench/i2c_master_bit_sequencer_unit_tb.sv
// Self-checking testbench for the I2C master bit sequencer unit.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_unit_tb;
  import i2cbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 10;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [2:0] operation_i;
  logic [7:0] write_data_i;
  logic       sda_sample_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       scl_level_o;
  logic       sda_level_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] read_data_o;
  logic       ack_missing_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_delay_ticks_i;

  i2c_master_bit_sequencer_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .write_data_i     (write_data_i),
    .sda_sample_i     (sda_sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .scl_level_o      (scl_level_o),
    .sda_level_o      (sda_level_o),
    .busy_res_o       (busy_res_o),
    .done_res_o       (done_res_o),
    .read_data_o      (read_data_o),
    .ack_missing_o    (ack_missing_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_delay_ticks_i(cfg_delay_ticks_i)
  );

  // Bus sequencer state as the testbench expects it to evolve.
  logic [DELAY_BITS-1:0] delay_cfg  = DELAY_RESET;
  cmd_e                  cur_cmd    = CMD_IDLE;
  logic [2:0]            cur_phase  = 3'd0;
  logic [3:0]            bits_done  = 4'd0;
  logic [DELAY_BITS-1:0] pause_left = '0;
  logic [7:0]            shreg      = 8'd0;
  logic                  scl_q      = 1'b1;
  logic                  sda_q      = 1'b1;
  logic                  ack_q      = 1'b0;
  logic [7:0]            rd_q       = 8'd0;

  res_t        bus_exp_q[$];
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned stall_left  = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Carries out the pin step of the current phase; returns 1 when the command ends.
  function automatic bit bus_step(input logic sda_in);
    logic [2:0] nxt;
    bit         fin;
    nxt = cur_phase + 3'd1;
    fin = 1'b0;
    case (cur_cmd)
      CMD_START: begin
        case (cur_phase)
          3'd0: begin
            sda_q = 1'b1;
            scl_q = 1'b1;
          end
          3'd1: sda_q = 1'b0;
          3'd2: scl_q = 1'b0;
          default: fin = 1'b1;
        endcase
      end
      CMD_STOP: begin
        if (cur_phase == 3'd0) begin
          sda_q = 1'b0;
          scl_q = 1'b1;
        end else begin
          sda_q = 1'b1;
          fin   = 1'b1;
        end
      end
      CMD_SEND: begin
        case (cur_phase)
          3'd0: sda_q = shreg[7];
          3'd1: scl_q = 1'b1;
          3'd2: begin
            scl_q = 1'b0;
            if (bits_done == 4'd7) sda_q = 1'b1;
            shreg     = shreg << 1;
            bits_done = bits_done + 4'd1;
            nxt       = (bits_done >= 4'd8) ? 3'd3 : 3'd0;
          end
          default: fin = 1'b1;
        endcase
      end
      CMD_READ: begin
        case (cur_phase)
          3'd0: scl_q = 1'b1;
          3'd1: begin
            shreg     = {shreg[6:0], sda_in};
            scl_q     = 1'b0;
            bits_done = bits_done + 4'd1;
            nxt       = (bits_done >= 4'd8) ? 3'd2 : 3'd0;
          end
          default: begin
            rd_q = shreg;
            fin  = 1'b1;
          end
        endcase
      end
      CMD_WAITACK, CMD_NACK: begin
        case (cur_phase)
          3'd0: sda_q = 1'b1;
          3'd1: scl_q = 1'b1;
          3'd2: begin
            if (cur_cmd == CMD_WAITACK) ack_q = sda_in;
            scl_q = 1'b0;
          end
          default: fin = 1'b1;
        endcase
      end
      CMD_ACK: begin
        case (cur_phase)
          3'd0: sda_q = 1'b0;
          3'd1: scl_q = 1'b1;
          3'd2: scl_q = 1'b0;
          default: begin
            sda_q = 1'b1;
            fin   = 1'b1;
          end
        endcase
      end
      default: fin = 1'b1;
    endcase
    if (!fin) begin
      cur_phase  = nxt;
      pause_left = delay_cfg;
    end
    return fin;
  endfunction

  function automatic res_t predict_tick(input cmd_e op, input logic [7:0] data,
                                        input logic sda);
    res_t r;
    bit   fin;
    fin = 1'b0;
    if (cur_cmd == CMD_IDLE) begin
      if (op != CMD_IDLE) begin
        cur_cmd    = op;
        cur_phase  = 3'd0;
        bits_done  = 4'd0;
        pause_left = '0;
        shreg      = (op == CMD_SEND) ? data : 8'd0;
        fin        = bus_step(sda);
      end
    end else if (pause_left <= 1) begin
      pause_left = '0;
      fin        = bus_step(sda);
    end else begin
      pause_left = pause_left - 1'b1;
    end
    if (fin) begin
      cur_cmd    = CMD_IDLE;
      cur_phase  = 3'd0;
      bits_done  = 4'd0;
      pause_left = '0;
    end
    r.scl_level   = scl_q;
    r.sda_level   = sda_q;
    r.busy_res    = (cur_cmd != CMD_IDLE);
    r.done_res    = fin;
    r.read_data   = rd_q;
    r.ack_missing = ack_q;
    return r;
  endfunction

  function automatic void report_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want)
      report_error($sformatf("%s expected %0h, got %0h", field, want, got));
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (bus_exp_q.size() == 0) begin
        report_error("result transaction arrived with nothing expected");
      end else begin
        want = bus_exp_q.pop_front();
        check_field("scl_level", want.scl_level, scl_level_o);
        check_field("sda_level", want.sda_level, sda_level_o);
        check_field("busy_res", want.busy_res, busy_res_o);
        check_field("done_res", want.done_res, done_res_o);
        check_field("read_data", want.read_data, read_data_o);
        check_field("ack_missing", want.ack_missing, ack_missing_o);
      end
    end
  end

  // The receiver stalls at random, and for one long stretch when a test asks for it.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req    = 1'b0;
      stall_left  = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left  = pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_tick(input cmd_e op, input logic [7:0] data, input logic sda);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    write_data_i <= data;
    sda_sample_i <= sda;
    do @(posedge clk_i); while (!in_ready_o);
    bus_exp_q.push_back(predict_tick(op, data, sda));
  endtask

  task automatic run_command(input cmd_e op, input logic [7:0] data, input logic sda);
    send_tick(op, data, sda);
    while (cur_cmd != CMD_IDLE) send_tick(CMD_IDLE, 8'($urandom), sda);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (bus_exp_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_delay(input logic [7:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_delay_ticks_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    delay_cfg = value[DELAY_BITS-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_tick(CMD_IDLE, 8'hFF, 1'b1);
    send_tick(CMD_IDLE, 8'h00, 1'b0);
    run_command(CMD_START, 8'h00, 1'b1);
    run_command(CMD_STOP, 8'hFF, 1'b0);
  endtask

  task automatic test_each_command();
    write_delay(8'd1);
    run_command(CMD_START, 8'h00, 1'b0);
    send_tick(CMD_SEND, 8'hFF, 1'b0);
    send_tick(CMD_STOP, 8'h00, 1'b1);
    run_command(CMD_IDLE, 8'h00, 1'b0);
    run_command(CMD_WAITACK, 8'h00, 1'b1);
    run_command(CMD_READ, 8'h00, 1'b1);
    run_command(CMD_ACK, 8'hFF, 1'b1);
    run_command(CMD_READ, 8'hFF, 1'b0);
    run_command(CMD_NACK, 8'h00, 1'b0);
    run_command(CMD_WAITACK, 8'hFF, 1'b0);
    run_command(CMD_SEND, 8'h00, 1'b1);
    run_command(CMD_STOP, 8'h00, 1'b0);
  endtask

  task automatic test_delay_extremes();
    write_delay(8'd0);
    run_command(CMD_NACK, 8'h5A, 1'b1);
    run_command(CMD_WAITACK, 8'hA5, 1'b0);
    write_delay(8'hFF);
    run_command(CMD_STOP, 8'h00, 1'b1);
  endtask

  task automatic test_backpressure();
    int n;
    write_delay(8'd2);
    steady = 1'b1;
    @(posedge clk_i);
    hold_req = 1'b1;
    send_tick(CMD_SEND, 8'($urandom), 1'($urandom));
    for (n = 0; n < 40; n++) send_tick(CMD_IDLE, 8'($urandom), 1'($urandom));
    steady = 1'b0;
    // The sender pauses in mid-command until every result has been taken.
    wait_drained();
    run_command(CMD_IDLE, 8'($urandom), 1'($urandom));
  endtask

  task automatic test_random_traffic();
    logic [7:0] delays[7];
    cmd_e       op;
    int         ph;
    int         n;
    delays = '{8'd1, 8'd2, 8'd0, 8'd3, 8'($urandom_range(1, 6)), 8'd4, 8'd1};
    for (ph = 0; ph < 7; ph++) begin
      write_delay(delays[ph]);
      steady = (ph == 2);
      for (n = 0; n < 30; n++) begin
        if (cur_cmd == CMD_IDLE && $urandom_range(0, 99) < 85)
          op = cmd_e'(3'($urandom_range(1, 7)));
        else if (cur_cmd != CMD_IDLE && $urandom_range(0, 99) < 8)
          op = cmd_e'(3'($urandom_range(1, 7)));
        else
          op = CMD_IDLE;
        send_tick(op, 8'($urandom), 1'($urandom));
      end
      run_command(CMD_IDLE, 8'($urandom), 1'($urandom));
      steady = 1'b0;
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    operation_i       = CMD_IDLE;
    write_data_i      = 8'd0;
    sda_sample_i      = 1'b0;
    out_ready_i       = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_delay_ticks_i = 8'd0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_each_command();
    test_delay_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (bus_exp_q.size() != 0)
      report_error($sformatf("%0d expected results never arrived", bus_exp_q.size()));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
